[rtl/page_cache_slot_lru_core_defines.svh]
// ----------------------------------------------------------------------------
// page cache slot lru: assertion macros
// shared concurrent-check helpers for the page cache core
// ----------------------------------------------------------------------------
`ifndef PAGE_CACHE_SLOT_LRU_CORE_DEFINES_SVH
`define PAGE_CACHE_SLOT_LRU_CORE_DEFINES_SVH

// same-cycle implication, held off during reset
`define PCSL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, held off during reset
`define PCSL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/pcsl_pkg.sv]
// ----------------------------------------------------------------------------
// pcsl_pkg
// types and constants shared by the page cache slot lru core and its cells
// ----------------------------------------------------------------------------
package pcsl_pkg;

  localparam int IDX_W      = 6;   // covers the largest slot count
  localparam int STAMP_W    = 32;
  localparam int CNT_W      = 32;
  localparam int CFG_W      = 5;
  localparam int SLOT_OUT_W = 4;

  // search token handed from cell to cell
  typedef struct packed {
    logic               vld;
    logic               hit;
    logic [IDX_W-1:0]   hit_idx;
    logic               free;
    logic [IDX_W-1:0]   free_idx;
    logic [STAMP_W-1:0] min_stamp;
    logic [IDX_W-1:0]   min_idx;
  } lru_carry_t;

  // slot update broadcast to all cells
  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   idx;
    logic [STAMP_W-1:0] stamp;
  } slot_wr_t;

  typedef enum logic {
    CTL_IDLE,
    CTL_SEARCH
  } ctl_state_t;

endpackage

[rtl/pcsl_slot_cell.sv]
// ----------------------------------------------------------------------------
// pcsl_slot_cell
// one cache slot: holds tag, valid and stamp, folds itself into the search
// token and passes the token on to the next cell
// ----------------------------------------------------------------------------
module pcsl_slot_cell
  import pcsl_pkg::*;
#(
  parameter int PAGE_BITS = 40,
  parameter int IDX       = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 active,
  input  logic [PAGE_BITS-1:0] page,
  input  slot_wr_t             wr,
  input  lru_carry_t           carry_in,
  output lru_carry_t           carry_out
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic [PAGE_BITS-1:0] tag;
  logic                 valid;
  logic [STAMP_W-1:0]   stamp;
  lru_carry_t           carry_next;

  always_comb begin
    carry_next = carry_in;
    if (active) begin
      if (!carry_in.hit && valid && (tag == page)) begin
        carry_next.hit     = 1'b1;
        carry_next.hit_idx = MY_IDX;
      end
      if (!carry_in.free && !valid) begin
        carry_next.free     = 1'b1;
        carry_next.free_idx = MY_IDX;
      end
      // strict less keeps the lowest index on ties
      if (stamp < carry_in.min_stamp) begin
        carry_next.min_stamp = stamp;
        carry_next.min_idx   = MY_IDX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= 1'b0;
      stamp     <= '0;
      carry_out <= '0;
    end else begin
      carry_out <= carry_next;
      if (wr.en && (wr.idx == MY_IDX)) begin
        valid <= 1'b1;
        stamp <= wr.stamp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && (wr.idx == MY_IDX)) begin
      tag <= page;
    end
  end

endmodule

[rtl/page_cache_slot_lru_core.sv]
// ----------------------------------------------------------------------------
// page_cache_slot_lru_core
// fully associative page-slot cache with timestamp lru replacement
// ----------------------------------------------------------------------------
// the accepted request is registered into launch, then the search token walks
//   the slot cell chain one cell per cycle and done is registered from its tail
// a new request is taken only after the token leaves the chain; busy holds until then
// the receiver cannot stall; each result beat is shown for one cycle on done
// reset: all slots invalid, stamps, time and hit/miss counts zero,
//   active_slots back to 16 (clipped to NUM_SLOTS)
`include "page_cache_slot_lru_core_defines.svh"

module page_cache_slot_lru_core
  import pcsl_pkg::*;
#(
  parameter int NUM_SLOTS = 16,
  parameter int PAGE_BITS = 40
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_W-1:0]      cfg_wr_data,
  input  logic                  start,
  output logic                  busy,
  input  logic [PAGE_BITS-1:0]  page_number,
  output logic                  done,
  output logic                  hit,
  output logic [SLOT_OUT_W-1:0] slot_index,
  output logic                  displaced_valid,
  output logic [CNT_W-1:0]      hit_total,
  output logic [CNT_W-1:0]      miss_total
);

  localparam logic [CFG_W-1:0] ACTIVE_RST = CFG_W'(16);

  ctl_state_t           state;
  ctl_state_t           state_next;
  logic [CFG_W-1:0]     active_slots;
  logic [IDX_W:0]       n_eff;
  logic [PAGE_BITS-1:0] page;
  logic                 launch;
  logic [STAMP_W-1:0]   time_counter;
  logic [CNT_W-1:0]     hit_count;
  logic [CNT_W-1:0]     miss_count;
  logic [CNT_W-1:0]     hit_count_next;
  logic [CNT_W-1:0]     miss_count_next;
  lru_carry_t           chain [0:NUM_SLOTS];
  lru_carry_t           tail;
  slot_wr_t             wr;
  logic [IDX_W-1:0]     sel_idx;
  logic                 displaced;
  logic                 accept;

  assign accept = start && (state == CTL_IDLE);

  // zero means one slot, anything above the built count is clipped
  always_comb begin
    if (active_slots == '0) begin
      n_eff = (IDX_W+1)'(1);
    end else if ((IDX_W+1)'(active_slots) > (IDX_W+1)'(NUM_SLOTS)) begin
      n_eff = (IDX_W+1)'(NUM_SLOTS);
    end else begin
      n_eff = (IDX_W+1)'(active_slots);
    end
  end

  always_comb begin
    chain[0]           = '0;
    chain[0].vld       = launch;
    chain[0].min_stamp = '1;
  end

  genvar gi;
  generate
    for (gi = 0; gi < NUM_SLOTS; gi++) begin : g_cell
      pcsl_slot_cell #(
        .PAGE_BITS (PAGE_BITS),
        .IDX       (gi)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .active    ((IDX_W+1)'(gi) < n_eff),
        .page      (page),
        .wr        (wr),
        .carry_in  (chain[gi]),
        .carry_out (chain[gi+1])
      );
    end
  endgenerate

  assign tail = chain[NUM_SLOTS];

  always_comb begin
    if (tail.hit) begin
      sel_idx = tail.hit_idx;
    end else if (tail.free) begin
      sel_idx = tail.free_idx;
    end else begin
      sel_idx = tail.min_idx;
    end
    displaced = !tail.hit && !tail.free;
    wr.en     = tail.vld;
    wr.idx    = sel_idx;
    wr.stamp  = time_counter;
  end

  always_comb begin
    hit_count_next  = hit_count;
    miss_count_next = miss_count;
    if (tail.hit) begin
      if (hit_count != '1) begin
        hit_count_next = hit_count + CNT_W'(1);
      end
    end else begin
      if (miss_count != '1) begin
        miss_count_next = miss_count + CNT_W'(1);
      end
    end
  end

  // controller
  always_comb begin
    state_next = state;
    case (state)
      CTL_IDLE: begin
        if (start) begin
          state_next = CTL_SEARCH;
        end
      end
      CTL_SEARCH: begin
        if (tail.vld) begin
          state_next = CTL_IDLE;
        end
      end
      default: state_next = CTL_IDLE;
    endcase
  end

  always_comb begin
    case (state)
      CTL_IDLE:   busy = 1'b0;
      CTL_SEARCH: busy = 1'b1;
      default:    busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= CTL_IDLE;
      launch       <= 1'b0;
      active_slots <= ACTIVE_RST;
      time_counter <= '0;
      hit_count    <= '0;
      miss_count   <= '0;
      done         <= 1'b0;
    end else begin
      state  <= state_next;
      launch <= accept;
      done   <= tail.vld;
      if (cfg_wr_en) begin
        active_slots <= cfg_wr_data;
      end
      if (tail.vld) begin
        time_counter <= time_counter + STAMP_W'(1);
        hit_count    <= hit_count_next;
        miss_count   <= miss_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      page <= page_number;
    end
    if (tail.vld) begin
      hit             <= tail.hit;
      slot_index      <= sel_idx[SLOT_OUT_W-1:0];
      displaced_valid <= displaced;
      hit_total       <= hit_count_next;
      miss_total      <= miss_count_next;
    end
  end

  `PCSL_ASSERT_NOW(a_done_idle, clk, rst, done, !busy, "result beat while busy")
  `PCSL_ASSERT_NEXT(a_accept_busy, clk, rst, accept, busy, "accepted request did not go busy")
  `PCSL_ASSERT_NOW(a_hit_no_evict, clk, rst, done && hit, !displaced_valid, "hit marked as displacing")
  `PCSL_ASSERT_NOW(a_tail_in_search, clk, rst, tail.vld, busy, "search token outside a request")

endmodule

[bench/page_cache_slot_lru_core_test.sv]
// ----------------------------------------------------------------------------
// page_cache_slot_lru_core_test
// drives page lookups and slot-count writes into the page cache core, mirrors
// the timestamp lru replacement in a local copy of the cache and checks every
// result beat (hit, slot, displacement, hit and miss totals) in order
// ----------------------------------------------------------------------------
module page_cache_slot_lru_core_test
  import pcsl_pkg::*;
;

  localparam int SLOTS        = 16;
  localparam int PAGE_W       = 40;
  localparam int RUN_LIMIT    = 200000;
  localparam int SETTLE       = SLOTS + 4;
  localparam int IDLE_PCT     = 26;
  localparam int PHASES       = 11;
  localparam int PHASE_ITEMS  = 50;
  localparam int POOL_SIZE    = 20;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic                  hit;
    logic [SLOT_OUT_W-1:0] slot;
    logic                  displaced;
    logic [CNT_W-1:0]      hits;
    logic [CNT_W-1:0]      misses;
  } lookup_beat_t;

  typedef enum logic {
    ROW_LOOKUP,
    ROW_SLOTS
  } row_kind_t;

  typedef struct {
    row_kind_t        kind;
    logic [PAGE_W-1:0] value;
    bit               fixed;
    lookup_beat_t     want;
  } stim_row_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [CFG_W-1:0]      cfg_wr_data;
  logic                  start;
  logic                  busy;
  logic [PAGE_W-1:0]     page_number;
  logic                  done;
  logic                  hit;
  logic [SLOT_OUT_W-1:0] slot_index;
  logic                  displaced_valid;
  logic [CNT_W-1:0]      hit_total;
  logic [CNT_W-1:0]      miss_total;

  // local copy of the cache
  logic [PAGE_W-1:0]  cached_page [SLOTS];
  bit                 cached_valid[SLOTS];
  logic [STAMP_W-1:0] cached_stamp[SLOTS];
  logic [STAMP_W-1:0] stamp_now;
  logic [CNT_W-1:0]   hit_tally;
  logic [CNT_W-1:0]   miss_tally;
  logic [CFG_W-1:0]   slots_cfg;

  lookup_beat_t due_lookups[$];
  bit           idle_on;
  int           cycle_count;
  int           mismatch_count;
  int           stray_count;
  int           beats_seen;
  int           hit_beats;
  int           displace_beats;
  int           lookups_sent;
  int           slot_writes;

  page_cache_slot_lru_core #(
    .NUM_SLOTS(SLOTS),
    .PAGE_BITS(PAGE_W)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .start          (start),
    .busy           (busy),
    .page_number    (page_number),
    .done           (done),
    .hit            (hit),
    .slot_index     (slot_index),
    .displaced_valid(displaced_valid),
    .hit_total      (hit_total),
    .miss_total     (miss_total)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int active_span();
    if (slots_cfg == '0) return 1;
    if (slots_cfg > SLOTS) return SLOTS;
    return int'(slots_cfg);
  endfunction

  // one lookup against the local cache, state updated in place
  function automatic lookup_beat_t lru_lookup(input logic [PAGE_W-1:0] pg);
    lookup_beat_t       r;
    int                 n;
    int                 pick;
    bit                 found;
    bit                 free_seen;
    logic [STAMP_W-1:0] oldest;
    r     = '0;
    n     = active_span();
    pick  = 0;
    found = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (!found && cached_valid[i] && cached_page[i] == pg) begin
        found = 1'b1;
        pick  = i;
      end
    end
    if (found) begin
      if (hit_tally != '1) hit_tally = hit_tally + 1;
    end else begin
      if (miss_tally != '1) miss_tally = miss_tally + 1;
      free_seen = 1'b0;
      for (int i = 0; i < n; i++) begin
        if (!free_seen && !cached_valid[i]) begin
          free_seen = 1'b1;
          pick      = i;
        end
      end
      if (!free_seen) begin
        // oldest stamp wins, strict compare keeps the lowest index on ties
        pick   = 0;
        oldest = cached_stamp[0];
        for (int i = 1; i < n; i++) begin
          if (cached_stamp[i] < oldest) begin
            oldest = cached_stamp[i];
            pick   = i;
          end
        end
        r.displaced = 1'b1;
      end
      cached_page[pick]  = pg;
      cached_valid[pick] = 1'b1;
    end
    cached_stamp[pick] = stamp_now;
    stamp_now          = stamp_now + 1;
    r.hit    = found;
    r.slot   = pick[SLOT_OUT_W-1:0];
    r.hits   = hit_tally;
    r.misses = miss_tally;
    return r;
  endfunction

  function automatic stim_row_t make_row(input row_kind_t k, input logic [PAGE_W-1:0] v,
                                         input bit f, input lookup_beat_t w);
    stim_row_t r;
    r.kind  = k;
    r.value = v;
    r.fixed = f;
    r.want  = w;
    return r;
  endfunction

  // offer one lookup beat, idling at random, until the core takes it
  task automatic issue_page(input logic [PAGE_W-1:0] pg, input bit fixed,
                            input lookup_beat_t want);
    bit           taken;
    lookup_beat_t model;
    taken = 1'b0;
    while (!taken) begin
      if (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
        start       <= 1'b0;
        page_number <= PAGE_W'({$urandom, $urandom} >> (64 - PAGE_W));
      end else begin
        start       <= 1'b1;
        page_number <= pg;
      end
      @(posedge clk);
      if (start && !busy) taken = 1'b1;
    end
    model = lru_lookup(pg);
    due_lookups.push_back(fixed ? want : model);
    lookups_sent++;
  endtask

  // drain, then write the slot count while the core sits idle
  task automatic write_slots(input logic [CFG_W-1:0] v);
    start <= 1'b0;
    @(posedge clk);
    while (due_lookups.size() != 0 || busy) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    slots_cfg = v;
    slot_writes++;
  endtask

  // result check
  always @(posedge clk) begin
    lookup_beat_t want;
    lookup_beat_t got;
    if (!rst && done) begin
      got = '{hit, slot_index, displaced_valid, hit_total, miss_total};
      beats_seen++;
      if (hit) hit_beats++;
      if (displaced_valid) displace_beats++;
      if (due_lookups.size() == 0) begin
        stray_count++;
        if (mismatch_count + stray_count <= REPORT_LIMIT)
          $display("unexpected result beat at cycle %0d: slot=%0d hit=%0b",
                   cycle_count, slot_index, hit);
      end else begin
        want = due_lookups.pop_front();
        if (got.hit !== want.hit || got.slot !== want.slot ||
            got.displaced !== want.displaced || got.hits !== want.hits ||
            got.misses !== want.misses) begin
          mismatch_count++;
          if (mismatch_count + stray_count <= REPORT_LIMIT) begin
            $display("mismatch at beat %0d: expected hit=%0b slot=%0d displaced=%0b",
                     beats_seen, want.hit, want.slot, want.displaced);
            $display("  expected hits=%0d misses=%0d", want.hits, want.misses);
            $display("  actual   hit=%0b slot=%0d displaced=%0b hits=%0d misses=%0d",
                     got.hit, got.slot, got.displaced, got.hits, got.misses);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("run stopped at cycle limit with %0d results outstanding", due_lookups.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    stim_row_t         rows[$];
    logic [PAGE_W-1:0] pool[POOL_SIZE];
    logic [PAGE_W-1:0] pg;
    logic [PAGE_W-1:0] ones;
    logic [CFG_W-1:0]  phase_slots[9];
    int                span;
    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    start       = 1'b0;
    page_number = '0;
    idle_on     = 1'b1;
    for (int i = 0; i < SLOTS; i++) begin
      cached_page[i]  = '0;
      cached_valid[i] = 1'b0;
      cached_stamp[i] = '0;
    end
    stamp_now      = '0;
    hit_tally      = '0;
    miss_tally     = '0;
    slots_cfg      = CFG_W'(16);
    cycle_count    = 0;
    mismatch_count = 0;
    stray_count    = 0;
    beats_seen     = 0;
    hit_beats      = 0;
    displace_beats = 0;
    lookups_sent   = 0;
    slot_writes    = 0;
    ones           = '1;
    phase_slots    = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd2, 5'd8, 5'd5, 5'd12};

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part: reset state, page extremes, slot-count corner values
    rows.push_back(make_row(ROW_LOOKUP, '0, 1, '{1'b0, 4'd0, 1'b0, 32'd0, 32'd1}));
    rows.push_back(make_row(ROW_LOOKUP, '0, 1, '{1'b1, 4'd0, 1'b0, 32'd1, 32'd1}));
    rows.push_back(make_row(ROW_LOOKUP, ones, 1, '{1'b0, 4'd1, 1'b0, 32'd1, 32'd2}));
    rows.push_back(make_row(ROW_LOOKUP, 40'h80_0000_0000, 1,
                            '{1'b0, 4'd2, 1'b0, 32'd1, 32'd3}));
    rows.push_back(make_row(ROW_LOOKUP, 40'h55_5555_5555, 0, '0));
    rows.push_back(make_row(ROW_LOOKUP, 40'hAA_AAAA_AAAA, 0, '0));
    rows.push_back(make_row(ROW_LOOKUP, ones, 1, '{1'b1, 4'd1, 1'b0, 32'd2, 32'd5}));
    // zero slots behaves as one
    rows.push_back(make_row(ROW_SLOTS, 40'd0, 0, '0));
    rows.push_back(make_row(ROW_LOOKUP, '0, 0, '0));
    rows.push_back(make_row(ROW_LOOKUP, ones, 0, '0));
    rows.push_back(make_row(ROW_LOOKUP, '0, 0, '0));
    // over-range count clips to the full cache, slot 1 kept its page meanwhile
    rows.push_back(make_row(ROW_SLOTS, 40'd31, 0, '0));
    rows.push_back(make_row(ROW_LOOKUP, ones, 0, '0));
    rows.push_back(make_row(ROW_SLOTS, 40'd2, 0, '0));
    rows.push_back(make_row(ROW_LOOKUP, 40'h10, 0, '0));
    rows.push_back(make_row(ROW_LOOKUP, 40'h11, 0, '0));
    rows.push_back(make_row(ROW_LOOKUP, 40'h10, 0, '0));
    rows.push_back(make_row(ROW_LOOKUP, 40'h12, 0, '0));
    rows.push_back(make_row(ROW_LOOKUP, 40'h11, 0, '0));
    rows.push_back(make_row(ROW_SLOTS, 40'd16, 0, '0));
    rows.push_back(make_row(ROW_LOOKUP, 40'h55_5555_5555, 0, '0));
    rows.push_back(make_row(ROW_LOOKUP, 40'h1, 0, '0));

    foreach (rows[k]) begin
      if (rows[k].kind == ROW_SLOTS) write_slots(rows[k].value[CFG_W-1:0]);
      else issue_page(rows[k].value, rows[k].fixed, rows[k].want);
    end

    // random part: a working set a little larger than the active slots,
    // with near-miss tags and some fully random pages mixed in
    for (int p = 0; p < PHASES; p++) begin
      write_slots(p < 9 ? phase_slots[p] : CFG_W'($urandom_range(0, 31)));
      idle_on = !(p == 4 || p == 5);
      for (int k = 0; k < POOL_SIZE; k++) begin
        if (k % 2 == 1 && $urandom_range(0, 1) == 1)
          pool[k] = pool[k-1] ^ (PAGE_W'(1) << $urandom_range(0, PAGE_W - 1));
        else
          pool[k] = PAGE_W'({$urandom, $urandom} >> (64 - PAGE_W));
      end
      span = active_span() + 3;
      if (span > POOL_SIZE - 1) span = POOL_SIZE - 1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 99) < 85) pg = pool[$urandom_range(0, span)];
        else pg = PAGE_W'({$urandom, $urandom} >> (64 - PAGE_W));
        issue_page(pg, 1'b0, '0);
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (due_lookups.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("%0d lookups over %0d slot-count settings (0 through 31 incl. clipping)",
             lookups_sent, slot_writes);
    $display("%0d result beats: %0d hits, %0d evictions of a valid page, %0d bad, %0d stray",
             beats_seen, hit_beats, displace_beats, mismatch_count, stray_count);
    if (mismatch_count == 0 && stray_count == 0 && due_lookups.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
